FILE: rtl/signed_integer_to_radix_digits_assert.svh
// assertion macros for the radix digit converter
// included by the top level; no other dependencies
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

`ifndef SYNTHESIS
`define SIRD_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);
`define SIRD_ASSERT(lbl, prop, msg) `SIRD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define SIRD_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg)
`define SIRD_ASSERT(lbl, prop, msg)
`endif

`endif

FILE: rtl/sird_pkg.sv
// shared types, constants and helpers for the radix digit converter
// used by sird_ctrl, sird_dp and the top level; no dependencies
`default_nettype none

package sird_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int VALUE_BITS = 32;

    localparam int DIGIT_W   = 4;
    localparam int STACK_D   = 32;
    localparam int STACK_AW  = $clog2(STACK_D);
    localparam int COUNT_W   = STACK_AW + 1;
    localparam int RADIX_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_LENGTH_RST = 5'd10;
    localparam logic [CFG_W-1:0]   SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]   SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    // floor(2^VALUE_BITS / d); entries outside 2..16 are never used
    localparam logic [63:0] RECIP_ONE = 64'd1 << VALUE_BITS;
    localparam logic [VALUE_BITS-1:0] RECIP [0:(1 << RADIX_W)-1] = '{
        2:  VALUE_BITS'(RECIP_ONE / 64'd2),
        3:  VALUE_BITS'(RECIP_ONE / 64'd3),
        4:  VALUE_BITS'(RECIP_ONE / 64'd4),
        5:  VALUE_BITS'(RECIP_ONE / 64'd5),
        6:  VALUE_BITS'(RECIP_ONE / 64'd6),
        7:  VALUE_BITS'(RECIP_ONE / 64'd7),
        8:  VALUE_BITS'(RECIP_ONE / 64'd8),
        9:  VALUE_BITS'(RECIP_ONE / 64'd9),
        10: VALUE_BITS'(RECIP_ONE / 64'd10),
        11: VALUE_BITS'(RECIP_ONE / 64'd11),
        12: VALUE_BITS'(RECIP_ONE / 64'd12),
        13: VALUE_BITS'(RECIP_ONE / 64'd13),
        14: VALUE_BITS'(RECIP_ONE / 64'd14),
        15: VALUE_BITS'(RECIP_ONE / 64'd15),
        16: VALUE_BITS'(RECIP_ONE / 64'd16),
        default: '1
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic div_done;
        logic negative;
        logic slot_free;
        logic one_left;
        logic has_digit;
    } status_t;

    function automatic logic [7:0] sym_at(input logic [CFG_W-1:0] lo,
                                          input logic [CFG_W-1:0] hi,
                                          input logic [DIGIT_W-1:0] idx);
        logic [CFG_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sird_ctrl.sv
// sequencer for the radix digit converter: accept, divide loop, emit loop
// depends on sird_pkg (state, command and status types)
`default_nettype none

module sird_ctrl
    import sird_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // a bad alphabet drops the request silently
                state_next = status.alpha_ok ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (status.div_done)
                begin
                    state_next = status.negative ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.one_left)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/sird_dp.sv
// datapath: config registers, alphabet check, reciprocal divider,
// digit stack and output register; depends on sird_pkg
`default_nettype none

module sird_dp
    import sird_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic signed [31:0]    value,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 character,
    output logic                       last
);

    logic [RADIX_W-1:0]      radix_len_reg;
    logic [CFG_W-1:0]        sym_lo_reg;
    logic [CFG_W-1:0]        sym_hi_reg;
    logic                    alpha_ok_reg;
    logic                    alpha_ok_next;

    logic [VALUE_BITS-1:0]   mag_reg;
    logic [VALUE_BITS-1:0]   mag_next;
    logic                    neg_reg;
    logic [2*VALUE_BITS-1:0] prod_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [DIGIT_W-1:0]      stack_mem [0:STACK_D-1];

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [7:0]              char_reg;
    logic                    last_reg;

    logic [VALUE_BITS-1:0]   raw;
    logic [VALUE_BITS-1:0]   q0;
    logic [VALUE_BITS+RADIX_W-1:0] q0_times_d;
    logic [VALUE_BITS-1:0]   r0;
    logic                    fix;
    logic [VALUE_BITS-1:0]   quot;
    logic [VALUE_BITS-1:0]   rem;
    logic [COUNT_W-1:0]      count_m1;
    logic                    slot_free;

    // alphabet check: length range, no sign symbols, no repeats
    always_comb
    begin
        logic [7:0] si;
        alpha_ok_next = (radix_len_reg >= RADIX_W'(2))
                     && (radix_len_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++)
        begin
            si = sym_at(sym_lo_reg, sym_hi_reg, DIGIT_W'(i));
            if (RADIX_W'(i) < radix_len_reg)
            begin
                if (si == PLUS_CHAR || si == MINUS_CHAR)
                begin
                    alpha_ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++)
                begin
                    if (RADIX_W'(j) < radix_len_reg
                        && si == sym_at(sym_lo_reg, sym_hi_reg, DIGIT_W'(j)))
                    begin
                        alpha_ok_next = 1'b0;
                    end
                end
            end
        end
    end

    // quotient estimate from the reciprocal is low by at most one
    always_comb
    begin
        raw        = value[VALUE_BITS-1:0];
        q0         = prod_reg[2*VALUE_BITS-1:VALUE_BITS];
        q0_times_d = q0 * radix_len_reg;
        r0         = mag_reg - q0_times_d[VALUE_BITS-1:0];
        fix        = r0 >= VALUE_BITS'(radix_len_reg);
        quot       = q0 + VALUE_BITS'(fix);
        rem        = fix ? (r0 - VALUE_BITS'(radix_len_reg)) : r0;
        count_m1   = count_reg - COUNT_W'(1);
        slot_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        mag_next   = mag_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            mag_next   = raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - raw) : raw;
            count_next = '0;
        end
        else if (cmd.div)
        begin
            mag_next   = quot;
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            count_next = count_m1;
        end

        if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_len_reg <= RADIX_LENGTH_RST;
            sym_lo_reg    <= SYMBOLS_LOW_RST;
            sym_hi_reg    <= SYMBOLS_HIGH_RST;
            alpha_ok_reg  <= 1'b1;
            mag_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RADIX_LENGTH: radix_len_reg <= cfg_data[RADIX_W-1:0];
                    REG_SYMBOLS_LOW:  sym_lo_reg    <= cfg_data;
                    REG_SYMBOLS_HIGH: sym_hi_reg    <= cfg_data;
                    default:          ;
                endcase
            end
            alpha_ok_reg  <= alpha_ok_next;
            mag_reg       <= mag_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= raw[VALUE_BITS-1];
        end
        if (cmd.mul)
        begin
            prod_reg <= mag_reg * RECIP[radix_len_reg];
        end
        if (cmd.div)
        begin
            stack_mem[count_reg[STACK_AW-1:0]] <= rem[DIGIT_W-1:0];
        end
        if (cmd.emit_sign)
        begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sym_at(sym_lo_reg, sym_hi_reg,
                               stack_mem[count_m1[STACK_AW-1:0]]);
            last_reg <= (count_reg == COUNT_W'(1));
        end
    end

    always_comb
    begin
        status.alpha_ok  = alpha_ok_reg;
        status.div_done  = (quot == '0) || (count_reg[STACK_AW-1:0] == '1);
        status.negative  = neg_reg;
        status.slot_free = slot_free;
        status.one_left  = (count_reg == COUNT_W'(1));
        status.has_digit = (count_reg != '0);
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: rtl/signed_integer_to_radix_digits.sv
// flow: the request is taken, the alphabet is checked, then for each digit
// a reciprocal multiply, then correct and push; then one character per cycle
// when not stalled, sign first; next request taken the cycle after the last
// character is loaded into the output register
// invalid alphabet: no output; reset: async active low, radix 10
`default_nettype none

`include "signed_integer_to_radix_digits_assert.svh"

module signed_integer_to_radix_digits
    import sird_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [31:0]   value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                character,
    output logic                      last
);

    cmd_t    cmd;
    status_t status;

    sird_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sird_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    // busy right after a request is taken
    `SIRD_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "not busy after request")
    // while idle only a final character may be pending
    `SIRD_ASSERT(a_idle_pending_last, (!in_stall && out_valid) |-> last, "idle with text unfinished")
    // never pop an empty digit stack
    `SIRD_ASSERT(a_pop_nonempty, cmd.emit_digit |-> status.has_digit, "digit pop on empty stack")

endmodule

`default_nettype wire

FILE: verif/signed_integer_to_radix_digits_tb.sv
// testbench for signed_integer_to_radix_digits: drives values and alphabets,
// predicts every character and last flag, checks them in order
// depends on sird_pkg and the block's rtl only
`timescale 1ns / 100ps

module signed_integer_to_radix_digits_tb;
    import sird_pkg::*;

    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int BLOCK_ITEMS   = 7;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } text_char_t;

    class radix_text_scoreboard;
        logic [RADIX_W-1:0] radix_len;
        logic [CFG_W-1:0]   sym_lo;
        logic [CFG_W-1:0]   sym_hi;
        text_char_t         pending_chars[$];
        int                 mismatches;

        function new();
            radix_len   = RADIX_LENGTH_RST;
            sym_lo      = SYMBOLS_LOW_RST;
            sym_hi      = SYMBOLS_HIGH_RST;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RADIX_LENGTH: radix_len = data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  sym_lo = data;
                REG_SYMBOLS_HIGH: sym_hi = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] glyph(logic [3:0] idx);
            logic [127:0] all_syms;
            all_syms = {sym_hi, sym_lo};
            return all_syms[idx*8 +: 8];
        endfunction

        function bit alphabet_ok();
            if (radix_len < 2 || radix_len > MAX_RADIX)
                return 1'b0;
            for (int i = 0; i < radix_len; i++)
            begin
                if (glyph(4'(i)) == PLUS_CHAR || glyph(4'(i)) == MINUS_CHAR)
                    return 1'b0;
                for (int j = i + 1; j < radix_len; j++)
                    if (glyph(4'(i)) == glyph(4'(j)))
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        // spell one accepted value into the expected character stream
        function void note_request(logic [31:0] v);
            logic [31:0] mag;
            logic [31:0] base;
            logic [3:0]  digits[$];
            text_char_t  c;
            if (!alphabet_ok())
                return;
            base = 32'(radix_len);
            mag  = v[31] ? 32'd0 - v : v;
            do
            begin
                digits.push_front(4'(mag % base));
                mag = mag / base;
            end
            while (mag != 0);
            if (v[31])
            begin
                c.ch      = MINUS_CHAR;
                c.is_last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digits[i])
            begin
                c.ch      = glyph(digits[i]);
                c.is_last = (i == digits.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_char(logic [7:0] ch, logic is_last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %h last %b", ch, is_last));
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch)
                report_mismatch($sformatf("character %h, expected %h", ch, want.ch));
            if (is_last !== want.is_last)
                report_mismatch($sformatf("last %b, expected %b", is_last, want.is_last));
        endtask

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_RADIX_LENGTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [31:0]   value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           character;
    logic                 last;

    radix_text_scoreboard sb = new();
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    signed_integer_to_radix_digits dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("signed_integer_to_radix_digits_tb NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_char(character, last);
    end

    function automatic logic [127:0] pack_syms(string s);
        logic [127:0] syms;
        syms = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            syms[i*8 +: 8] = s[i];
        return syms;
    endfunction

    function automatic logic [127:0] random_symbols();
        logic [127:0] syms;
        bit           taken[256];
        logic [7:0]   b;
        syms = '0;
        for (int i = 0; i < 16; i++)
        begin
            do
                b = 8'($urandom_range(255));
            while (taken[b] || b == PLUS_CHAR || b == MINUS_CHAR);
            taken[b] = 1'b1;
            syms[i*8 +: 8] = b;
        end
        return syms;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'($urandom_range(40));
            1: return 32'd0 - 32'($urandom_range(40));
            2: return {1'b1, 31'($urandom_range(15))};
            3: return {1'b0, {31{1'b1}}} - 32'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(v);
    endtask

    // drop valid and wait until every expected character has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_alphabet(input logic [RADIX_W-1:0] radix, input logic [127:0] syms);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RADIX_LENGTH;
        cfg_data  <= CFG_W'(radix);
        @(posedge clk);
        sb.set_reg(REG_RADIX_LENGTH, CFG_W'(radix));
        cfg_index <= REG_SYMBOLS_LOW;
        cfg_data  <= syms[63:0];
        @(posedge clk);
        sb.set_reg(REG_SYMBOLS_LOW, syms[63:0]);
        cfg_index <= REG_SYMBOLS_HIGH;
        cfg_data  <= syms[127:64];
        @(posedge clk);
        sb.set_reg(REG_SYMBOLS_HIGH, syms[127:64]);
        cfg_we <= 1'b0;
    endtask

    task automatic random_block(input int count);
        logic [127:0]       syms;
        logic [RADIX_W-1:0] radix;
        int                 k;
        radix = ($urandom_range(3) == 0) ? RADIX_W'($urandom_range(1) ? 2 : 16)
                                         : RADIX_W'($urandom_range(2, 16));
        syms = random_symbols();
        // now and then a broken alphabet first: a repeat or a sign symbol
        if ($urandom_range(3) == 0)
        begin
            k = $urandom_range(1, radix - 1);
            case ($urandom_range(2))
                0: syms[k*8 +: 8] = syms[7:0];
                1: syms[k*8 +: 8] = MINUS_CHAR;
                default: syms[k*8 +: 8] = PLUS_CHAR;
            endcase
            load_alphabet(radix, syms);
            send_value(pick_value());
            send_value(pick_value());
            settle();
            syms = random_symbols();
        end
        load_alphabet(radix, syms);
        repeat (count) send_value(pick_value());
        settle();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset alphabet, decimal
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd7);
        send_value(32'd0 - 32'd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1000000000);
        settle();

        load_alphabet(5'd2, pack_syms("01"));
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        settle();

        load_alphabet(5'd16, pack_syms("0123456789abcdef"));
        send_value(32'd255);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        settle();

        // zero byte is a plain symbol; a plus past the radix length is harmless
        load_alphabet(5'd3, 128'h2B79_7800);
        send_value(32'd0 - 32'd5);
        send_value(32'd100);
        settle();

        // symbol 8 taken from an all-ones high word
        load_alphabet(5'd9, pack_syms("abcdefgh") | {64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
        send_value(32'd0 - 32'd12345);
        send_value(32'd8);
        settle();

        // invalid alphabets give no output at all
        load_alphabet(5'd0, pack_syms("0123456789"));
        send_value(32'd42);
        settle();
        load_alphabet(5'd1, pack_syms("0123456789"));
        send_value(32'd0 - 32'd42);
        settle();
        load_alphabet(5'd17, pack_syms("0123456789abcdef"));
        send_value(32'd17);
        settle();
        load_alphabet(5'd31, pack_syms("0123456789abcdef"));
        send_value(32'd0);
        settle();
        load_alphabet(5'd4, pack_syms("01-3"));
        send_value(32'd9);
        settle();
        load_alphabet(5'd2, pack_syms("+1"));
        send_value(32'd3);
        settle();
        load_alphabet(5'd4, pack_syms("0120"));
        send_value(32'd5);
        settle();
        load_alphabet(5'd2, 128'd0);
        send_value(32'd1);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            repeat (3) random_block(BLOCK_ITEMS);
        end

        // long receiver hold-off while the sender keeps offering requests
        idle_pct  = 0;
        stall_pct = 0;
        load_alphabet(5'd2, random_symbols());
        hold_requests++;
        repeat (12) send_value(pick_value());
        settle();

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d characters never came out", sb.pending()));
        if (sb.mismatches == 0)
            $display("signed_integer_to_radix_digits_tb OK");
        else
            $display("signed_integer_to_radix_digits_tb NOT OK");
        $finish;
    end

endmodule

FILE: signed_integer_to_radix_digits.f
+incdir+rtl
rtl/sird_pkg.sv
rtl/sird_ctrl.sv
rtl/sird_dp.sv
rtl/signed_integer_to_radix_digits.sv
verif/signed_integer_to_radix_digits_tb.sv
